FILE: rtl/point_translate_scale_rotate_defines.svh
// Assertion shorthands shared by the transform pipeline.
`ifndef POINT_TRANSLATE_SCALE_ROTATE_DEFINES_SVH
`define POINT_TRANSLATE_SCALE_ROTATE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define PTS_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define PTS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pts_pkg.sv
package pts_pkg;

    typedef longint unsigned u64_t;

    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int OUT_W          = 32;
    localparam int ANG_W          = 10;
    localparam int ANGN_W         = 9;
    localparam int QTR_W          = 7;

    localparam int FULL_TURN  = 360;
    localparam int QUARTER    = 90;
    localparam int HALF_TURN  = 180;
    localparam int THREE_QTR  = 270;

    localparam u64_t PI_Q31  = 64'd6746518852;
    localparam u64_t ONE_Q31 = 64'd2147483648;

    typedef enum logic [1:0] {
        MODE_TRANSLATE = 2'd0,
        MODE_SCALE     = 2'd1,
        MODE_ROTATE    = 2'd2,
        MODE_PASS      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    typedef struct packed {
        logic  valid;
        mode_t mode;
    } ctl_t;

    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic [TRIG_FRAC_BITS:0]   trig_mag_t;
    typedef trig_mag_t                 sin_tab_t [0:QUARTER];
    typedef logic signed [ANG_W:0]     ang_ext_t;
    typedef logic [ANGN_W-1:0]         ang_t;
    typedef logic [QTR_W-1:0]          qtr_t;

    localparam trig_t TRIG_ONE = trig_t'(1 << TRIG_FRAC_BITS);

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic u64_t qmul31(input u64_t a, input u64_t b);
        return (a * b) >> 31;
    endfunction

    // Quarter-wave sine by Taylor series in Q1.31, clamped, then rounded to nearest.
    function automatic trig_mag_t quarter_sin(input int d);
        u64_t   x;
        u64_t   x2;
        u64_t   term;
        longint sum;
        x    = (PI_Q31 * u64_t'(d) + 64'd90) / 64'd180;
        x2   = qmul31(x, x);
        term = x;
        sum  = longint'(x);
        term = qmul31(term, x2) / 64'd6;   sum = sum - longint'(term);
        term = qmul31(term, x2) / 64'd20;  sum = sum + longint'(term);
        term = qmul31(term, x2) / 64'd42;  sum = sum - longint'(term);
        term = qmul31(term, x2) / 64'd72;  sum = sum + longint'(term);
        term = qmul31(term, x2) / 64'd110; sum = sum - longint'(term);
        term = qmul31(term, x2) / 64'd156; sum = sum + longint'(term);
        term = qmul31(term, x2) / 64'd210; sum = sum - longint'(term);
        term = qmul31(term, x2) / 64'd272; sum = sum + longint'(term);
        term = qmul31(term, x2) / 64'd342; sum = sum - longint'(term);
        term = qmul31(term, x2) / 64'd420; sum = sum + longint'(term);
        term = qmul31(term, x2) / 64'd506; sum = sum - longint'(term);
        term = qmul31(term, x2) / 64'd600; sum = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q31))
        begin
            sum = longint'(ONE_Q31);
        end
        sum = (sum + (longint'(1) <<< (30 - TRIG_FRAC_BITS))) >>> (31 - TRIG_FRAC_BITS);
        return trig_mag_t'(sum);
    endfunction

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t tab;
        for (int d = 0; d <= QUARTER; d++)
        begin
            tab[d] = quarter_sin(d);
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

FILE: rtl/pts_trig.sv
`include "point_translate_scale_rotate_defines.svh"

module pts_trig import pts_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  ctl_t                          in_ctl,
    input  logic signed [ANG_W-1:0]       angle,
    input  logic signed [COORD_WIDTH-1:0] x_in,
    input  logic signed [COORD_WIDTH-1:0] y_in,
    input  logic signed [COORD_WIDTH-1:0] dx,
    input  logic signed [COORD_WIDTH-1:0] dy,
    input  logic signed [COORD_WIDTH-1:0] sx,
    input  logic signed [COORD_WIDTH-1:0] sy,
    output ctl_t                          ctl_c,
    output trig_t                         sin_c,
    output trig_t                         cos_c,
    output logic signed [COORD_WIDTH-1:0] x_c,
    output logic signed [COORD_WIDTH-1:0] y_c,
    output logic signed [COORD_WIDTH-1:0] dx_c,
    output logic signed [COORD_WIDTH-1:0] dy_c,
    output logic signed [COORD_WIDTH-1:0] sx_c,
    output logic signed [COORD_WIDTH-1:0] sy_c
);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] dx;
        logic signed [COORD_WIDTH-1:0] dy;
        logic signed [COORD_WIDTH-1:0] sx;
        logic signed [COORD_WIDTH-1:0] sy;
    } pt_t;

    ctl_t     ctl_a_reg;
    ctl_t     ctl_b_reg;
    ctl_t     ctl_c_reg;
    pt_t      pt_in;
    pt_t      pt_a_reg;
    pt_t      pt_b_reg;
    pt_t      pt_c_reg;
    ang_t     ang_a_reg;
    ang_t     ang_a_next;
    quad_t    quad_b_reg;
    quad_t    quad_b_next;
    qtr_t     r_b_reg;
    qtr_t     r_b_next;
    qtr_t     rc_b_reg;
    qtr_t     rc_b_next;
    trig_t    sin_c_reg;
    trig_t    sin_c_next;
    trig_t    cos_c_reg;
    trig_t    cos_c_next;
    ang_ext_t a1;
    ang_ext_t a2;
    ang_ext_t a3;
    ang_t     diff;
    trig_t    sr_pos;
    trig_t    cr_pos;

    assign pt_in = '{x: x_in, y: y_in, dx: dx, dy: dy, sx: sx, sy: sy};

    // Fold the angle into 0..359
    always_comb
    begin
        a1 = ang_ext_t'(angle);
        if (a1 < 0)
        begin
            a1 = a1 + ang_ext_t'(FULL_TURN);
        end
        a2 = a1;
        if (a2 < 0)
        begin
            a2 = a2 + ang_ext_t'(FULL_TURN);
        end
        a3 = a2;
        if (a3 >= ang_ext_t'(FULL_TURN))
        begin
            a3 = a3 - ang_ext_t'(FULL_TURN);
        end
        ang_a_next = ang_t'(a3);
    end

    // Split into quadrant and residue within the quadrant
    always_comb
    begin
        if (ang_a_reg >= ang_t'(THREE_QTR))
        begin
            quad_b_next = QUAD_IV;
            diff        = ang_a_reg - ang_t'(THREE_QTR);
        end
        else if (ang_a_reg >= ang_t'(HALF_TURN))
        begin
            quad_b_next = QUAD_III;
            diff        = ang_a_reg - ang_t'(HALF_TURN);
        end
        else if (ang_a_reg >= ang_t'(QUARTER))
        begin
            quad_b_next = QUAD_II;
            diff        = ang_a_reg - ang_t'(QUARTER);
        end
        else
        begin
            quad_b_next = QUAD_I;
            diff        = ang_a_reg;
        end
        r_b_next  = qtr_t'(diff);
        rc_b_next = qtr_t'(QUARTER) - qtr_t'(diff);
    end

    assign sr_pos = trig_t'(SIN_TAB[r_b_reg]);
    assign cr_pos = trig_t'(SIN_TAB[rc_b_reg]);

    always_comb
    begin
        case (quad_b_reg)
            QUAD_I:
            begin
                sin_c_next = sr_pos;
                cos_c_next = cr_pos;
            end
            QUAD_II:
            begin
                sin_c_next = cr_pos;
                cos_c_next = -sr_pos;
            end
            QUAD_III:
            begin
                sin_c_next = -sr_pos;
                cos_c_next = -cr_pos;
            end
            default:
            begin
                sin_c_next = -cr_pos;
                cos_c_next = sr_pos;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else if (adv)
        begin
            ctl_a_reg <= in_ctl;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_a_reg   <= pt_in;
            ang_a_reg  <= ang_a_next;
            pt_b_reg   <= pt_a_reg;
            quad_b_reg <= quad_b_next;
            r_b_reg    <= r_b_next;
            rc_b_reg   <= rc_b_next;
            pt_c_reg   <= pt_b_reg;
            sin_c_reg  <= sin_c_next;
            cos_c_reg  <= cos_c_next;
        end
    end

    assign ctl_c = ctl_c_reg;
    assign sin_c = sin_c_reg;
    assign cos_c = cos_c_reg;
    assign x_c   = pt_c_reg.x;
    assign y_c   = pt_c_reg.y;
    assign dx_c  = pt_c_reg.dx;
    assign dy_c  = pt_c_reg.dy;
    assign sx_c  = pt_c_reg.sx;
    assign sy_c  = pt_c_reg.sy;

    `PTS_ASSERT_NEXT(a_quad_split, clk, rst_n, adv && ctl_a_reg.valid, (QUARTER * int'(quad_b_reg) + int'(r_b_reg)) == int'($past(ang_a_reg)) && int'(r_b_reg) < QUARTER, "quadrant split does not rebuild the angle")
    `PTS_ASSERT_NEXT(a_zero_angle, clk, rst_n, adv && ctl_b_reg.valid && quad_b_reg == QUAD_I && r_b_reg == '0, sin_c_reg == '0 && cos_c_reg == TRIG_ONE, "zero angle gives wrong sine or cosine")

endmodule

FILE: rtl/pts_mul.sv
module pts_mul import pts_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     adv,
    input  ctl_t                                     ctl_c,
    input  trig_t                                    sin_c,
    input  trig_t                                    cos_c,
    input  logic signed [COORD_WIDTH-1:0]            x_c,
    input  logic signed [COORD_WIDTH-1:0]            y_c,
    input  logic signed [COORD_WIDTH-1:0]            dx_c,
    input  logic signed [COORD_WIDTH-1:0]            dy_c,
    input  logic signed [COORD_WIDTH-1:0]            sx_c,
    input  logic signed [COORD_WIDTH-1:0]            sy_c,
    output ctl_t                                     ctl_d,
    output logic signed [COORD_WIDTH+max_int(COORD_WIDTH, TRIG_W)-1:0] p0_d,
    output logic signed [COORD_WIDTH+max_int(COORD_WIDTH, TRIG_W)-1:0] p1_d,
    output logic signed [COORD_WIDTH+max_int(COORD_WIDTH, TRIG_W)-1:0] p2_d,
    output logic signed [COORD_WIDTH+max_int(COORD_WIDTH, TRIG_W)-1:0] p3_d,
    output logic signed [COORD_WIDTH:0]              tx_d,
    output logic signed [COORD_WIDTH:0]              ty_d,
    output logic signed [COORD_WIDTH-1:0]            x_d,
    output logic signed [COORD_WIDTH-1:0]            y_d
);

    localparam int BW = max_int(COORD_WIDTH, TRIG_W);
    localparam int PW = COORD_WIDTH + BW;

    ctl_t                          ctl_d_reg;
    logic signed [BW-1:0]          bx;
    logic signed [BW-1:0]          by;
    logic signed [PW-1:0]          p0_next;
    logic signed [PW-1:0]          p1_next;
    logic signed [PW-1:0]          p2_next;
    logic signed [PW-1:0]          p3_next;
    logic signed [PW-1:0]          p0_reg;
    logic signed [PW-1:0]          p1_reg;
    logic signed [PW-1:0]          p2_reg;
    logic signed [PW-1:0]          p3_reg;
    logic signed [COORD_WIDTH:0]   tx_next;
    logic signed [COORD_WIDTH:0]   ty_next;
    logic signed [COORD_WIDTH:0]   tx_reg;
    logic signed [COORD_WIDTH:0]   ty_reg;
    logic signed [COORD_WIDTH-1:0] x_reg;
    logic signed [COORD_WIDTH-1:0] y_reg;

    // Outer multipliers take the scale factors in scale mode, cosine otherwise
    assign bx = (ctl_c.mode == MODE_SCALE) ? BW'(sx_c) : BW'(cos_c);
    assign by = (ctl_c.mode == MODE_SCALE) ? BW'(sy_c) : BW'(cos_c);

    assign p0_next = PW'(x_c) * PW'(bx);
    assign p1_next = PW'(y_c) * PW'(sin_c);
    assign p2_next = PW'(x_c) * PW'(sin_c);
    assign p3_next = PW'(y_c) * PW'(by);
    assign tx_next = (COORD_WIDTH+1)'(x_c) + (COORD_WIDTH+1)'(dx_c);
    assign ty_next = (COORD_WIDTH+1)'(y_c) + (COORD_WIDTH+1)'(dy_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d_reg <= '0;
        end
        else if (adv)
        begin
            ctl_d_reg <= ctl_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            tx_reg <= tx_next;
            ty_reg <= ty_next;
            x_reg  <= x_c;
            y_reg  <= y_c;
        end
    end

    assign ctl_d = ctl_d_reg;
    assign p0_d  = p0_reg;
    assign p1_d  = p1_reg;
    assign p2_d  = p2_reg;
    assign p3_d  = p3_reg;
    assign tx_d  = tx_reg;
    assign ty_d  = ty_reg;
    assign x_d   = x_reg;
    assign y_d   = y_reg;

endmodule

FILE: rtl/pts_round.sv
`include "point_translate_scale_rotate_defines.svh"

module pts_round import pts_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     adv,
    input  ctl_t                                     ctl_d,
    input  logic signed [COORD_WIDTH+max_int(COORD_WIDTH, TRIG_W)-1:0] p0_d,
    input  logic signed [COORD_WIDTH+max_int(COORD_WIDTH, TRIG_W)-1:0] p1_d,
    input  logic signed [COORD_WIDTH+max_int(COORD_WIDTH, TRIG_W)-1:0] p2_d,
    input  logic signed [COORD_WIDTH+max_int(COORD_WIDTH, TRIG_W)-1:0] p3_d,
    input  logic signed [COORD_WIDTH:0]              tx_d,
    input  logic signed [COORD_WIDTH:0]              ty_d,
    input  logic signed [COORD_WIDTH-1:0]            x_d,
    input  logic signed [COORD_WIDTH-1:0]            y_d,
    output logic                                     out_valid,
    output logic signed [OUT_W-1:0]                  x_out,
    output logic signed [OUT_W-1:0]                  y_out
);

    localparam int BW    = max_int(COORD_WIDTH, TRIG_W);
    localparam int PW    = COORD_WIDTH + BW;
    localparam int SW    = PW + 1;
    localparam int EXT_W = max_int(SW, OUT_W);
    localparam logic [SW-1:0] RND_HALF = SW'(1) << (TRIG_FRAC_BITS - 1);

    ctl_t                    ctl_e_reg;
    logic signed [SW-1:0]    ex_next;
    logic signed [SW-1:0]    ey_next;
    logic signed [SW-1:0]    ex_e_reg;
    logic signed [SW-1:0]    ey_e_reg;
    logic signed [SW-1:0]    xr;
    logic signed [SW-1:0]    yr;
    logic signed [EXT_W-1:0] xw;
    logic signed [EXT_W-1:0] yw;
    logic signed [OUT_W-1:0] x_out_next;
    logic signed [OUT_W-1:0] y_out_next;
    logic signed [OUT_W-1:0] x_out_reg;
    logic signed [OUT_W-1:0] y_out_reg;
    logic                    out_valid_reg;

    function automatic logic signed [SW-1:0] round_half_away(input logic signed [SW-1:0] v);
        logic [SW-1:0] mag;
        logic [SW-1:0] rnd;
        mag = v[SW-1] ? -v : v;
        rnd = (mag + RND_HALF) >> TRIG_FRAC_BITS;
        return v[SW-1] ? -$signed(rnd) : $signed(rnd);
    endfunction

    // Pick the pre-rounding value for each mode
    always_comb
    begin
        case (ctl_d.mode)
            MODE_TRANSLATE:
            begin
                ex_next = SW'(tx_d);
                ey_next = SW'(ty_d);
            end
            MODE_SCALE:
            begin
                ex_next = SW'(p0_d);
                ey_next = SW'(p3_d);
            end
            MODE_ROTATE:
            begin
                ex_next = SW'(p0_d) - SW'(p1_d);
                ey_next = SW'(p2_d) + SW'(p3_d);
            end
            default:
            begin
                ex_next = SW'(x_d);
                ey_next = SW'(y_d);
            end
        endcase
    end

    // Only rotation carries fraction bits; wrap to the output width
    always_comb
    begin
        if (ctl_e_reg.mode == MODE_ROTATE)
        begin
            xr = round_half_away(ex_e_reg);
            yr = round_half_away(ey_e_reg);
        end
        else
        begin
            xr = ex_e_reg;
            yr = ey_e_reg;
        end
        xw         = EXT_W'(xr);
        yw         = EXT_W'(yr);
        x_out_next = xw[OUT_W-1:0];
        y_out_next = yw[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_e_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ctl_e_reg     <= ctl_d;
            out_valid_reg <= ctl_e_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_e_reg  <= ex_next;
            ey_e_reg  <= ey_next;
            x_out_reg <= x_out_next;
            y_out_reg <= y_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign x_out     = x_out_reg;
    assign y_out     = y_out_reg;

    `PTS_ASSERT_NEXT(a_valid_follows, clk, rst_n, adv, out_valid == $past(ctl_e_reg.valid), "output valid lost or invented")
    `PTS_ASSERT_NEXT(a_rotate_origin, clk, rst_n, adv && ctl_e_reg.valid && ctl_e_reg.mode == MODE_ROTATE && ex_e_reg == '0 && ey_e_reg == '0, x_out == '0 && y_out == '0, "rotated origin does not stay at origin")
    `PTS_ASSERT_SAME(a_held_out, clk, rst_n, !adv, out_valid, "pipeline held without a waiting result")

endmodule

FILE: rtl/point_translate_scale_rotate.sv
// Channel  | Handshake            | Fields
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_stall  | mode, x_in, y_in, dx, dy, sx, sy, angle
// out      | out_valid / out_stall| x_out, y_out
//
// One point per cycle unless a held result stalls; out_valid rises once the point
// has passed six register stages (angle fold, quadrant split,
// sine table, multipliers, sum, rounding into the output register).
// Reset clears only the control registers (valid and mode bits); no state survives between points.
// A waiting result under out_stall freezes every stage and raises in_stall.
module point_translate_scale_rotate import pts_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    mode,
    input  logic signed [COORD_WIDTH-1:0] x_in,
    input  logic signed [COORD_WIDTH-1:0] y_in,
    input  logic signed [COORD_WIDTH-1:0] dx,
    input  logic signed [COORD_WIDTH-1:0] dy,
    input  logic signed [COORD_WIDTH-1:0] sx,
    input  logic signed [COORD_WIDTH-1:0] sy,
    input  logic signed [ANG_W-1:0]       angle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_W-1:0]       x_out,
    output logic signed [OUT_W-1:0]       y_out
);

    localparam int BW = max_int(COORD_WIDTH, TRIG_W);
    localparam int PW = COORD_WIDTH + BW;

    logic                          adv;
    ctl_t                          in_ctl;
    ctl_t                          ctl_c;
    ctl_t                          ctl_d;
    trig_t                         sin_c;
    trig_t                         cos_c;
    logic signed [COORD_WIDTH-1:0] x_c;
    logic signed [COORD_WIDTH-1:0] y_c;
    logic signed [COORD_WIDTH-1:0] dx_c;
    logic signed [COORD_WIDTH-1:0] dy_c;
    logic signed [COORD_WIDTH-1:0] sx_c;
    logic signed [COORD_WIDTH-1:0] sy_c;
    logic signed [PW-1:0]          p0_d;
    logic signed [PW-1:0]          p1_d;
    logic signed [PW-1:0]          p2_d;
    logic signed [PW-1:0]          p3_d;
    logic signed [COORD_WIDTH:0]   tx_d;
    logic signed [COORD_WIDTH:0]   ty_d;
    logic signed [COORD_WIDTH-1:0] x_d;
    logic signed [COORD_WIDTH-1:0] y_d;

    // Advance the whole pipeline unless the result in the output register is held
    assign adv      = ~(out_valid & out_stall);
    assign in_stall = ~adv;
    assign in_ctl   = '{valid: in_valid, mode: mode_t'(mode)};

    pts_trig #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_trig (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_ctl (in_ctl),
        .angle  (angle),
        .x_in   (x_in),
        .y_in   (y_in),
        .dx     (dx),
        .dy     (dy),
        .sx     (sx),
        .sy     (sy),
        .ctl_c  (ctl_c),
        .sin_c  (sin_c),
        .cos_c  (cos_c),
        .x_c    (x_c),
        .y_c    (y_c),
        .dx_c   (dx_c),
        .dy_c   (dy_c),
        .sx_c   (sx_c),
        .sy_c   (sy_c)
    );

    pts_mul #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .ctl_c  (ctl_c),
        .sin_c  (sin_c),
        .cos_c  (cos_c),
        .x_c    (x_c),
        .y_c    (y_c),
        .dx_c   (dx_c),
        .dy_c   (dy_c),
        .sx_c   (sx_c),
        .sy_c   (sy_c),
        .ctl_d  (ctl_d),
        .p0_d   (p0_d),
        .p1_d   (p1_d),
        .p2_d   (p2_d),
        .p3_d   (p3_d),
        .tx_d   (tx_d),
        .ty_d   (ty_d),
        .x_d    (x_d),
        .y_d    (y_d)
    );

    pts_round #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl_d     (ctl_d),
        .p0_d      (p0_d),
        .p1_d      (p1_d),
        .p2_d      (p2_d),
        .p3_d      (p3_d),
        .tx_d      (tx_d),
        .ty_d      (ty_d),
        .x_d       (x_d),
        .y_d       (y_d),
        .out_valid (out_valid),
        .x_out     (x_out),
        .y_out     (y_out)
    );

endmodule
